// ===== hw/rtl/vlqp_pkg.sv =====
// Shared types and constants for the voxel level quantiser and packer.
// No dependencies; every other file imports this package.
package vlqp_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CCOUNT_W   = 3;
  localparam int unsigned IN_CHANS   = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_ZERO   = 3'd0,
    REG_THR_ONE    = 3'd1,
    REG_THR_TWO    = 3'd2,
    REG_THR_THREE  = 3'd3,
    REG_FOUR_LEVEL = 3'd4,
    REG_CHAN_COUNT = 3'd5
  } reg_idx_t;

  typedef logic [1:0] level_t;

  // Live configuration seen by the lanes, the merge and the packer
  typedef struct packed {
    logic [CHAN_W-1:0]   thr_one;
    logic [CHAN_W-1:0]   thr_two;
    logic [CHAN_W-1:0]   thr_three;
    logic                four_level;
    logic [CCOUNT_W-1:0] chan_count;
  } cfg_t;

  // Threshold hits found by one lane
  typedef struct packed {
    logic ge_one;
    logic ge_two;
    logic ge_three;
  } meet_t;

  // Voxel after quantisation, waiting for the packer
  typedef struct packed {
    level_t level;
    logic   last;
    logic   first;
  } qvox_t;

endpackage

// ===== hw/rtl/vlqp_if.sv =====
// Valid/ready channel interfaces for voxels in and packed bytes out.
// Depends on vlqp_pkg for field widths.
interface vlqp_in_if import vlqp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan_a;
  logic [CHAN_W-1:0] chan_b;
  logic [CHAN_W-1:0] chan_c;
  logic [CHAN_W-1:0] chan_d;
  logic              last_of_block;
  logic              first_of_volume;

  modport source (output valid, chan_a, chan_b, chan_c, chan_d, last_of_block,
                  first_of_volume, input ready);
  modport sink   (input valid, chan_a, chan_b, chan_c, chan_d, last_of_block,
                  first_of_volume, output ready);
endinterface

interface vlqp_out_if import vlqp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  packed_byte;
  logic               block_end;
  logic               block_kept;
  logic [TOTAL_W-1:0] nonzero_total;

  modport source (output valid, packed_byte, block_end, block_kept, nonzero_total,
                  input ready);
  modport sink   (input valid, packed_byte, block_end, block_kept, nonzero_total,
                  output ready);
endinterface

// ===== hw/rtl/vlqp_lane.sv =====
// One channel lane: compares its intensity against the level thresholds.
// Depends on vlqp_pkg.
module vlqp_lane import vlqp_pkg::*; (
  input  logic [CHAN_W-1:0] chan,
  input  logic              enable,
  input  cfg_t              cfg,
  output meet_t             meet
);

  // Drop the lane from the maximum when the channel is not in use
  always_comb begin
    meet.ge_one   = enable && (chan >= cfg.thr_one);
    meet.ge_two   = enable && (chan >= cfg.thr_two);
    meet.ge_three = enable && (chan >= cfg.thr_three);
  end

endmodule

// ===== hw/rtl/vlqp_merge.sv =====
// Merge of the lane results into the voxel level.
// Depends on vlqp_pkg; fed by the vlqp_lane instances.
module vlqp_merge import vlqp_pkg::*; #(
  parameter int unsigned LANES = 4
) (
  input  meet_t [LANES-1:0] meets,
  input  cfg_t              cfg,
  output level_t            level
);

  logic any_one;
  logic any_two;
  logic any_three;

  // The maximum starts at zero, so a zero threshold is always met
  always_comb begin
    any_one   = (cfg.thr_one == '0);
    any_two   = (cfg.thr_two == '0);
    any_three = (cfg.thr_three == '0);
    for (int i = 0; i < LANES; i++) begin
      any_one   = any_one | meets[i].ge_one;
      any_two   = any_two | meets[i].ge_two;
      any_three = any_three | meets[i].ge_three;
    end
  end

  // Highest level whose threshold is met; upper levels in four-level mode only
  always_comb begin
    if (cfg.four_level && any_three) begin
      level = 2'd3;
    end else if (cfg.four_level && any_two) begin
      level = 2'd2;
    end else if (any_one) begin
      level = 2'd1;
    end else begin
      level = 2'd0;
    end
  end

endmodule

// ===== hw/rtl/vlqp_pack.sv =====
// Bit packer, block flag, nonzero counter and output register.
// Depends on vlqp_pkg and the vlqp_out_if interface.
module vlqp_pack import vlqp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vox_valid,
  input  qvox_t             vox,
  input  logic              four_level,
  output logic              vox_take,
  vlqp_out_if.source        out_ch
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [BYTE_W-1:0]      accum_r,   accum_nxt;
  logic [SLOT_W-1:0]      pos_r,     pos_nxt;
  logic                   any_r,     any_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r,     cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]      out_byte_r;
  logic                   out_end_r;
  logic                   out_kept_r;
  logic [TOTAL_W-1:0]     out_total_r;

  logic                   nz;
  logic [COUNT_WIDTH-1:0] cnt_base;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [BYTE_W+1:0]      code_shift;
  logic [BYTE_W-1:0]      accum_new;
  logic [SLOT_W:0]        next_pos;
  logic                   any_new;
  logic                   emit;
  logic [TOTAL_W-1:0]     total_new;

  // Take a voxel whenever the output register is free or being drained
  assign vox_take = vox_valid && (!out_valid_r || out_ch.ready);

  // Place the code and advance the slot
  always_comb begin
    nz         = (vox.level != 2'd0);
    cnt_base   = vox.first ? '0 : cnt_r;
    cnt_new    = (nz && (cnt_base != CNT_MAX)) ? cnt_base + 1'b1 : cnt_base;
    code_shift = {{BYTE_W{1'b0}}, vox.level} << pos_r;
    accum_new  = accum_r | code_shift[BYTE_W-1:0];
    next_pos   = {1'b0, pos_r} + (four_level ? 4'd2 : 4'd1);
    any_new    = any_r | nz;
    emit       = vox.last || next_pos[SLOT_W];
  end

  // Show the count on the output, truncated or zero-extended to TOTAL_W bits
  generate
    if (COUNT_WIDTH >= TOTAL_W) begin : g_total_trunc
      assign total_new = cnt_new[TOTAL_W-1:0];
    end else begin : g_total_ext
      assign total_new = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, cnt_new};
    end
  endgenerate

  // Next packing state; clear the byte after each emit and the flag at block end
  always_comb begin
    accum_nxt     = accum_r;
    pos_nxt       = pos_r;
    any_nxt       = any_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (vox_take) begin
      cnt_nxt = cnt_new;
      if (emit) begin
        accum_nxt     = '0;
        pos_nxt       = '0;
        any_nxt       = vox.last ? 1'b0 : any_new;
        out_valid_nxt = 1'b1;
      end else begin
        accum_nxt = accum_new;
        pos_nxt   = next_pos[SLOT_W-1:0];
        any_nxt   = any_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      pos_r       <= '0;
      any_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      pos_r       <= pos_nxt;
      any_r       <= any_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload on an emitting transfer
  always_ff @(posedge clk) begin
    if (vox_take && emit) begin
      out_byte_r  <= accum_new;
      out_end_r   <= vox.last;
      out_kept_r  <= vox.last && any_new;
      out_total_r <= total_new;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.packed_byte   = out_byte_r;
  assign out_ch.block_end     = out_end_r;
  assign out_ch.block_kept    = out_kept_r;
  assign out_ch.nonzero_total = out_total_r;

  // Block end leaves the packer empty
  a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (vox_take && vox.last) |=> (pos_r == '0 && accum_r == '0 && !any_r))
    else $error("packer state not cleared after block end");

  // Count only moves backwards on a volume restart
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (vox_take && !vox.first) |=> (cnt_r >= $past(cnt_r)))
    else $error("nonzero count decreased without volume restart");

  // Kept flag only accompanies a block end
  a_kept_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kept_r) |-> out_end_r)
    else $error("block_kept without block_end");

  // Never overwrite a pending result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_byte_r)))
    else $error("pending result lost or overwritten");

endmodule

// ===== hw/rtl/voxel_level_quantize_pack.sv =====
// Voxel level quantiser and packer: one voxel in per cycle, packed bytes out.
// A closing voxel passes the quantised voxel stage; the packer then registers its byte.
// Throughput: one voxel per cycle while out_ch.ready stays high; one byte
// per eight voxels (two-level) or four voxels (four-level), or at each block end.
// Reset (synchronous, rst_n low) clears the packer, counter, flag and pipeline valids,
// and returns the configuration to thresholds 0, two-level mode, one channel.
module voxel_level_quantize_pack import vlqp_pkg::*; #(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vlqp_in_if.sink               in_ch,
  vlqp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned LANES = (CHANNELS < IN_CHANS) ? CHANNELS : IN_CHANS;

  cfg_t                    cfg_r, cfg_nxt;
  logic [IN_CHANS-1:0][CHAN_W-1:0] chans;
  meet_t [LANES-1:0]       meets;
  level_t                  level;
  logic                    s1_valid_r, s1_valid_nxt;
  qvox_t                   s1_vox_r;
  logic                    s1_take;

  // Configuration writes; level zero threshold has no effect and is not kept
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_THR_ZERO:   cfg_nxt = cfg_r;
        REG_THR_ONE:    cfg_nxt.thr_one    = cfg_wdata;
        REG_THR_TWO:    cfg_nxt.thr_two    = cfg_wdata;
        REG_THR_THREE:  cfg_nxt.thr_three  = cfg_wdata;
        REG_FOUR_LEVEL: cfg_nxt.four_level = cfg_wdata[0];
        REG_CHAN_COUNT: cfg_nxt.chan_count = cfg_wdata[CCOUNT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_one    <= '0;
      cfg_r.thr_two    <= '0;
      cfg_r.thr_three  <= '0;
      cfg_r.four_level <= 1'b0;
      cfg_r.chan_count <= CCOUNT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign chans[0] = in_ch.chan_a;
  assign chans[1] = in_ch.chan_b;
  assign chans[2] = in_ch.chan_c;
  assign chans[3] = in_ch.chan_d;

  // One compare lane per channel, up to four; lanes beyond chan_count are disabled
  generate
    for (genvar i = 0; i < LANES; i++) begin : g_lane
      vlqp_lane u_lane (
        .chan   (chans[i]),
        .enable (cfg_r.chan_count > CCOUNT_W'(i)),
        .cfg    (cfg_r),
        .meet   (meets[i])
      );
    end
  endgenerate

  vlqp_merge #(
    .LANES (LANES)
  ) u_merge (
    .meets (meets),
    .cfg   (cfg_r),
    .level (level)
  );

  // Quantised voxel stage; refill while the packer drains it, hold off during reset
  assign in_ch.ready  = rst_n && (!s1_valid_r || s1_take);
  assign s1_valid_nxt = (in_ch.valid && in_ch.ready) || (s1_valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_vox_r.level <= level;
      s1_vox_r.last  <= in_ch.last_of_block;
      s1_vox_r.first <= in_ch.first_of_volume;
    end
  end

  vlqp_pack #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .vox_valid  (s1_valid_r),
    .vox        (s1_vox_r),
    .four_level (cfg_r.four_level),
    .vox_take   (s1_take),
    .out_ch     (out_ch)
  );

endmodule
